### rtl/pcmt_pkg.sv
// pcmt_pkg: types, codes and constants of the press-count mode toggle
// used by pcmt_cfg, pcmt_step and press_count_mode_toggle_core
// no dependencies
package pcmt_pkg;

    localparam int TICK_W  = 16;
    localparam int CNT_W   = 16;
    localparam int PRESS_W = 4;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int PCODE_W = 3;
    localparam int BLINK_BIT = 8;

    localparam logic [PRESS_W-1:0] PRESS_MAX = 4'd15;

    localparam logic [IDX_W-1:0] CFG_START_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PRESS_WINDOW     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_REQUIRED_PRESSES = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CHANGED_TICKS    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FEEDBACK_TICKS   = 3'd4;

    localparam logic [PCODE_W-1:0] PCODE_IDLE     = 3'd0;
    localparam logic [PCODE_W-1:0] PCODE_COUNTING = 3'd1;
    localparam logic [PCODE_W-1:0] PCODE_CHANGED  = 3'd2;
    localparam logic [PCODE_W-1:0] PCODE_FEEDBACK = 3'd3;
    localparam logic [PCODE_W-1:0] PCODE_LOCKED   = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_COUNTING = 5'b00010,
        PH_CHANGED  = 5'b00100,
        PH_FEEDBACK = 5'b01000,
        PH_LOCKED   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic               start_mode;
        logic [CNT_W-1:0]   press_window;
        logic [PRESS_W-1:0] required_presses;
        logic [CNT_W-1:0]   changed_ticks;
        logic [CNT_W-1:0]   feedback_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   countdown;
        logic [PRESS_W-1:0] press_total;
        logic               button_held;
        logic               chance_spent;
        phase_t             phase;
        logic               mode_flip;
    } state_t;

    typedef struct packed {
        logic              unplugged;
        logic [TICK_W-1:0] tick_value;
        logic              button_down;
    } item_t;

    typedef struct packed {
        logic               mode_now;
        logic               led_write;
        logic               led_red;
        logic               led_grn;
        logic               save_strobe;
        logic [PCODE_W-1:0] phase;
    } result_t;

    function automatic logic [PCODE_W-1:0] phase_code(input phase_t ph);
        logic [PCODE_W-1:0] code;
        case (ph)
            PH_IDLE:     code = PCODE_IDLE;
            PH_COUNTING: code = PCODE_COUNTING;
            PH_CHANGED:  code = PCODE_CHANGED;
            PH_FEEDBACK: code = PCODE_FEEDBACK;
            PH_LOCKED:   code = PCODE_LOCKED;
            default:     code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### rtl/pcmt_cfg.sv
// pcmt_cfg: configuration register file of the press-count mode toggle
// depends on pcmt_pkg
module pcmt_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pcmt_pkg::IDX_W-1:0] cfg_index,
    input  logic [pcmt_pkg::CFG_W-1:0] cfg_data,
    output pcmt_pkg::cfg_t             cfg
);
    import pcmt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MODE:       cfg_next.start_mode       = cfg_data[0];
                CFG_PRESS_WINDOW:     cfg_next.press_window     = cfg_data[CNT_W-1:0];
                CFG_REQUIRED_PRESSES: cfg_next.required_presses = cfg_data[PRESS_W-1:0];
                CFG_CHANGED_TICKS:    cfg_next.changed_ticks    = cfg_data[CNT_W-1:0];
                CFG_FEEDBACK_TICKS:   cfg_next.feedback_ticks   = cfg_data[CNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mode       <= 1'b0;
            cfg_reg.press_window     <= 16'd1000;
            cfg_reg.required_presses <= 4'd5;
            cfg_reg.changed_ticks    <= 16'd1000;
            cfg_reg.feedback_ticks   <= 16'd2000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pcmt_step.sv
// pcmt_step: next-state and result logic for one polled item
// depends on pcmt_pkg
module pcmt_step #(
    parameter int SEEN_BITS = 16
) (
    input  pcmt_pkg::cfg_t         cfg,
    input  pcmt_pkg::state_t       st,
    input  logic [SEEN_BITS-1:0]   tick_seen,
    input  pcmt_pkg::item_t        item,
    output pcmt_pkg::state_t       st_next,
    output logic [SEEN_BITS-1:0]   tick_seen_next,
    output pcmt_pkg::result_t      res
);
    import pcmt_pkg::*;

    logic [SEEN_BITS-1:0] tick;
    logic                 blink;
    logic                 mode;

    assign tick  = item.tick_value[SEEN_BITS-1:0];
    assign blink = tick[BLINK_BIT];

    always_comb
    begin
        st_next        = st;
        tick_seen_next = tick_seen;
        res            = '0;
        mode           = 1'b0;

        if (item.unplugged)
        begin
            st_next.press_total  = '0;
            st_next.phase        = PH_IDLE;
            st_next.chance_spent = 1'b0;
        end
        else if (tick != tick_seen)
        begin
            tick_seen_next = tick;

            // window expiry judges the press count
            if (st.countdown != '0)
            begin
                st_next.countdown = st.countdown - CNT_W'(1);
                if (st_next.countdown == '0 && st.phase == PH_COUNTING)
                begin
                    if (st.press_total == cfg.required_presses && !st.chance_spent)
                    begin
                        st_next.mode_flip    = ~st.mode_flip;
                        res.save_strobe      = 1'b1;
                        st_next.chance_spent = 1'b1;
                        st_next.phase        = PH_CHANGED;
                        st_next.countdown    = cfg.changed_ticks;
                    end
                    else if (!st.chance_spent)
                    begin
                        st_next.press_total = '0;
                        st_next.phase       = PH_IDLE;
                    end
                    else
                    begin
                        st_next.phase = PH_LOCKED;
                    end
                end
            end

            // led feedback
            if (st_next.phase == PH_CHANGED)
            begin
                res.led_write = 1'b1;
                res.led_red   = 1'b1;
                res.led_grn   = 1'b1;
                if (st_next.countdown == '0)
                begin
                    st_next.phase     = PH_FEEDBACK;
                    st_next.countdown = cfg.feedback_ticks;
                end
            end
            else if (st_next.phase == PH_FEEDBACK)
            begin
                mode          = cfg.start_mode ^ st_next.mode_flip;
                res.led_write = 1'b1;
                res.led_red   = blink;
                res.led_grn   = mode ? blink : ~blink;
                if (st_next.countdown == '0)
                begin
                    st_next.phase = PH_LOCKED;
                end
            end

            // press edge counting
            if (item.button_down && !st.button_held)
            begin
                st_next.button_held = 1'b1;
                if (st_next.phase == PH_IDLE || st_next.phase == PH_COUNTING)
                begin
                    if (st_next.press_total < PRESS_MAX)
                    begin
                        st_next.press_total = st_next.press_total + PRESS_W'(1);
                    end
                    st_next.countdown = cfg.press_window;
                    st_next.phase     = PH_COUNTING;
                    if (st_next.press_total > cfg.required_presses)
                    begin
                        st_next.chance_spent = 1'b1;
                        st_next.phase        = PH_LOCKED;
                    end
                end
            end
            else if (!item.button_down && st.button_held)
            begin
                st_next.button_held = 1'b0;
            end
        end

        res.mode_now = cfg.start_mode ^ st_next.mode_flip;
        res.phase    = phase_code(st_next.phase);
    end

endmodule

### rtl/press_count_mode_toggle_core.sv
// press_count_mode_toggle_core: top level of the press-count mode toggle
// path: input register, step logic, result register
// throughput: one item per cycle while out_ready holds, set by the
//   combinational step logic between the input register and the result register
// reset: registers at 0, 1000, 5, 1000, 2000; gesture state cleared, phase idle
// depends on pcmt_pkg, pcmt_cfg and pcmt_step
module press_count_mode_toggle_core #(
    parameter int TICK_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pcmt_pkg::IDX_W-1:0] cfg_index,
    input  logic [pcmt_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       unplugged,
    input  logic [pcmt_pkg::TICK_W-1:0] tick_value,
    input  logic                       button_down,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       mode_now,
    output logic                       led_write,
    output logic                       led_red,
    output logic                       led_grn,
    output logic                       save_strobe,
    output logic [pcmt_pkg::PCODE_W-1:0] phase
);
    import pcmt_pkg::*;

    localparam int SEEN_BITS = (TICK_BITS < TICK_W) ? TICK_BITS : TICK_W;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    advance;

    state_t  st_reg;
    state_t  st_next;
    logic [SEEN_BITS-1:0] tick_seen_reg;
    logic [SEEN_BITS-1:0] tick_seen_next;

    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    pcmt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcmt_step #(
        .SEEN_BITS (SEEN_BITS)
    ) u_step (
        .cfg            (cfg),
        .st             (st_reg),
        .tick_seen      (tick_seen_reg),
        .item           (in_item_reg),
        .st_next        (st_next),
        .tick_seen_next (tick_seen_next),
        .res            (res)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_seen_reg <= '0;
            st_reg.countdown    <= '0;
            st_reg.press_total  <= '0;
            st_reg.button_held  <= 1'b0;
            st_reg.chance_spent <= 1'b0;
            st_reg.phase        <= PH_IDLE;
            st_reg.mode_flip    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg        <= st_next;
                tick_seen_reg <= tick_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.unplugged   <= unplugged;
            in_item_reg.tick_value  <= tick_value;
            in_item_reg.button_down <= button_down;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode_now    = out_reg.mode_now;
    assign led_write   = out_reg.led_write;
    assign led_red     = out_reg.led_red;
    assign led_grn     = out_reg.led_grn;
    assign save_strobe = out_reg.save_strobe;
    assign phase       = out_reg.phase;

    // a zero changed_ticks moves straight on to feedback in the toggling item
    a_save_in_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.save_strobe |->
            (out_reg.phase == PCODE_CHANGED || out_reg.phase == PCODE_FEEDBACK))
        else $error("save strobe outside changed phase");

    a_led_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.led_write |-> !out_reg.led_red && !out_reg.led_grn)
        else $error("led level driven without led write");

    a_locked_spent: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == PH_LOCKED |-> st_reg.chance_spent)
        else $error("locked phase without spent chance");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while result register empty");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for press_count_mode_toggle_core, random idling on both sides
// directed stimulus table, then press gestures with noise under several register settings
// depends on pcmt_pkg and press_count_mode_toggle_core
module tb;
    import pcmt_pkg::*;

    typedef enum bit {ROW_POLL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   data;
        logic               u;
        logic [TICK_W-1:0]  t;
        logic               b;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    typedef struct packed {
        logic [TICK_W-1:0]  last_tick;
        logic [CNT_W-1:0]   timer;
        logic [PRESS_W-1:0] presses;
        logic               held;
        logic               spent;
        logic [PCODE_W-1:0] stage;
        logic               flipped;
    } gesture_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic unplugged;
    logic [TICK_W-1:0] tick_value;
    logic button_down;
    logic out_valid;
    logic out_ready;
    logic mode_now;
    logic led_write;
    logic led_red;
    logic led_grn;
    logic save_strobe;
    logic [PCODE_W-1:0] phase;

    cfg_t regs;
    gesture_t gesture;
    result_t expected_polls[$];
    stim_row_t directed_rows[$];
    logic [TICK_W-1:0] tick_now;
    int mismatches = 0;
    int polls_sent = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_rx = 1'b0;

    press_count_mode_toggle_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .unplugged   (unplugged),
        .tick_value  (tick_value),
        .button_down (button_down),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mode_now    (mode_now),
        .led_write   (led_write),
        .led_red     (led_red),
        .led_grn     (led_grn),
        .save_strobe (save_strobe),
        .phase       (phase)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t predict_poll(logic u, logic [TICK_W-1:0] t, logic b);
        result_t r;
        logic blink;
        r = '0;
        if (u)
        begin
            gesture.presses = '0;
            gesture.stage = PCODE_IDLE;
            gesture.spent = 1'b0;
        end
        else if (t != gesture.last_tick)
        begin
            gesture.last_tick = t;
            if (gesture.timer != 0)
            begin
                gesture.timer = gesture.timer - 1'b1;
                if (gesture.timer == 0 && gesture.stage == PCODE_COUNTING)
                begin
                    if (gesture.presses == regs.required_presses && !gesture.spent)
                    begin
                        gesture.flipped = ~gesture.flipped;
                        r.save_strobe = 1'b1;
                        gesture.spent = 1'b1;
                        gesture.stage = PCODE_CHANGED;
                        gesture.timer = regs.changed_ticks;
                    end
                    else if (!gesture.spent)
                    begin
                        gesture.presses = '0;
                        gesture.stage = PCODE_IDLE;
                    end
                    else
                    begin
                        gesture.stage = PCODE_LOCKED;
                    end
                end
            end
            if (gesture.stage == PCODE_CHANGED)
            begin
                r.led_write = 1'b1;
                r.led_red = 1'b1;
                r.led_grn = 1'b1;
                if (gesture.timer == 0)
                begin
                    gesture.stage = PCODE_FEEDBACK;
                    gesture.timer = regs.feedback_ticks;
                end
            end
            else if (gesture.stage == PCODE_FEEDBACK)
            begin
                blink = t[BLINK_BIT];
                r.led_write = 1'b1;
                r.led_red = blink;
                r.led_grn = (regs.start_mode ^ gesture.flipped) ? blink : ~blink;
                if (gesture.timer == 0)
                    gesture.stage = PCODE_LOCKED;
            end
            if (b && !gesture.held)
            begin
                gesture.held = 1'b1;
                if (gesture.stage == PCODE_IDLE || gesture.stage == PCODE_COUNTING)
                begin
                    if (gesture.presses != PRESS_MAX)
                        gesture.presses = gesture.presses + 1'b1;
                    gesture.timer = regs.press_window;
                    gesture.stage = PCODE_COUNTING;
                    if (gesture.presses > regs.required_presses)
                    begin
                        gesture.spent = 1'b1;
                        gesture.stage = PCODE_LOCKED;
                    end
                end
            end
            else if (!b && gesture.held)
            begin
                gesture.held = 1'b0;
            end
        end
        r.mode_now = regs.start_mode ^ gesture.flipped;
        r.phase = gesture.stage;
        return r;
    endfunction

    function automatic result_t shown(logic m, logic lw, logic red, logic green, logic save,
                                      logic [PCODE_W-1:0] ph);
        result_t r;
        r.mode_now = m;
        r.led_write = lw;
        r.led_red = red;
        r.led_grn = green;
        r.save_strobe = save;
        r.phase = ph;
        return r;
    endfunction

    function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(logic u, logic [TICK_W-1:0] t, logic b, result_t want);
        stim_row_t row;
        row = '0;
        row.kind = ROW_POLL;
        row.u = u;
        row.t = t;
        row.b = b;
        row.typed = 1'b1;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_poll(logic u, logic [TICK_W-1:0] t, logic b);
        add_known(u, t, b, '0);
        directed_rows[directed_rows.size()-1].typed = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic offer(input logic u, input logic [TICK_W-1:0] t, input logic b,
                         input bit typed, input result_t want);
        int gap;
        result_t guess;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 63) == 0)
            tx_steady = !tx_steady;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        unplugged <= u;
        tick_value <= t;
        button_down <= b;
        do @(posedge clk); while (!in_ready);
        guess = predict_poll(u, t, b);
        expected_polls.push_back(typed ? want : guess);
        polls_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_polls.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_START_MODE:       regs.start_mode = data[0];
            CFG_PRESS_WINDOW:     regs.press_window = data;
            CFG_REQUIRED_PRESSES: regs.required_presses = data[PRESS_W-1:0];
            CFG_CHANGED_TICKS:    regs.changed_ticks = data;
            CFG_FEEDBACK_TICKS:   regs.feedback_ticks = data;
            default:              ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_regs(input cfg_t c);
        drain();
        write_reg(CFG_START_MODE, CFG_W'(c.start_mode));
        write_reg(CFG_PRESS_WINDOW, c.press_window);
        write_reg(CFG_REQUIRED_PRESSES, CFG_W'(c.required_presses));
        write_reg(CFG_CHANGED_TICKS, c.changed_ticks);
        write_reg(CFG_FEEDBACK_TICKS, c.feedback_ticks);
        cfg_we <= 1'b0;
    endtask

    // n polls at level b (at times flipped if fidget), tick mostly advancing by one
    task automatic poll_ticks(input logic u, input logic b, input int n, input bit fidget);
        logic lvl;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) != 0)
                tick_now = tick_now + 1'b1;
            lvl = (fidget && $urandom_range(0, 5) == 0) ? ~b : b;
            offer(u, tick_now, lvl, 1'b0, '0);
        end
    endtask

    task automatic press_gesture();
        int presses;
        int span;
        int rest;
        if ($urandom_range(0, 4) != 0)
            poll_ticks(1'b1, 1'b0, 1, 1'b0);
        presses = regs.required_presses;
        case ($urandom_range(0, 5))
            0: if (presses > 0) presses--;
            1: presses++;
            default: ;
        endcase
        if (regs.required_presses == PRESS_MAX)
            presses += $urandom_range(0, 2);
        if (regs.press_window > 8)
            span = 6;
        else if (regs.press_window >= 3)
            span = regs.press_window - 2;
        else
            span = 1;
        for (int p = 0; p < presses; p++)
        begin
            poll_ticks(1'b0, 1'b1, 1, 1'b0);
            poll_ticks(1'b0, 1'b0, $urandom_range(1, span), 1'b0);
        end
        rest = int'(regs.press_window) + int'(regs.changed_ticks) + int'(regs.feedback_ticks) + 3;
        if (rest > 40)
            rest = 40;
        poll_ticks(1'b0, 1'b0, rest, $urandom_range(0, 1));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_polls.size() == 0)
            begin
                $display("%0t: result with nothing expected, phase %0d", $time, phase);
                mismatches++;
            end
            else
            begin
                want = expected_polls.pop_front();
                check_field("mode_now", 3'(want.mode_now), 3'(mode_now));
                check_field("led_write", 3'(want.led_write), 3'(led_write));
                check_field("led_red", 3'(want.led_red), 3'(led_red));
                check_field("led_grn", 3'(want.led_grn), 3'(led_grn));
                check_field("save_strobe", 3'(want.save_strobe), 3'(save_strobe));
                check_field("phase", want.phase, phase);
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (120) @(negedge clk);
                hold_rx = 1'b0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : run_limit
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t c;
        int quota;
        int target;
        bit writing;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        unplugged = 1'b0;
        tick_value = '0;
        button_down = 1'b0;
        regs.start_mode = 1'b0;
        regs.press_window = 16'd1000;
        regs.required_presses = 4'd5;
        regs.changed_ticks = 16'd1000;
        regs.feedback_ticks = 16'd2000;
        gesture = '0;
        writing = 1'b0;

        add_known(1'b0, 16'd0, 1'b0, shown(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PCODE_IDLE));
        add_write(CFG_PRESS_WINDOW, 16'd3);
        add_write(CFG_REQUIRED_PRESSES, 16'd2);
        add_write(CFG_CHANGED_TICKS, 16'd1);
        add_write(CFG_FEEDBACK_TICKS, 16'd1);
        add_poll(1'b0, 16'd1, 1'b1);
        add_poll(1'b0, 16'd2, 1'b0);
        add_poll(1'b0, 16'd3, 1'b1);
        add_poll(1'b0, 16'd3, 1'b0);
        add_poll(1'b0, 16'd4, 1'b0);
        add_poll(1'b0, 16'd5, 1'b0);
        add_known(1'b0, 16'd6, 1'b0, shown(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, PCODE_CHANGED));
        add_poll(1'b0, 16'd7, 1'b1);
        add_poll(1'b0, 16'h0100, 1'b0);
        add_poll(1'b0, 16'hFFFF, 1'b1);
        add_known(1'b1, 16'h1234, 1'b1, shown(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PCODE_IDLE));
        add_write(CFG_START_MODE, 16'd1);
        add_known(1'b0, 16'hFFFF, 1'b0, shown(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PCODE_IDLE));
        add_write(CFG_REQUIRED_PRESSES, 16'd1);
        add_poll(1'b0, 16'd0, 1'b1);
        add_poll(1'b0, 16'd1, 1'b0);
        add_poll(1'b0, 16'd2, 1'b1);
        add_poll(1'b1, 16'd2, 1'b0);
        add_write(CFG_PRESS_WINDOW, 16'd0);
        add_poll(1'b0, 16'd3, 1'b0);
        add_poll(1'b0, 16'd4, 1'b1);
        add_poll(1'b0, 16'd5, 1'b0);
        add_poll(1'b0, 16'd6, 1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    drain();
                    writing = 1'b1;
                end
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                if (writing)
                begin
                    cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                offer(directed_rows[i].u, directed_rows[i].t, directed_rows[i].b,
                      directed_rows[i].typed, directed_rows[i].want);
            end
        end

        tick_now = 16'd6;
        for (int ph = 0; ph < 10; ph++)
        begin
            c.start_mode = $urandom_range(0, 1);
            c.press_window = $urandom_range(3, 8);
            c.required_presses = $urandom_range(1, 4);
            c.changed_ticks = $urandom_range(1, 5);
            c.feedback_ticks = $urandom_range(1, 8);
            case (ph)
                0:
                begin
                    c.start_mode = 1'b0;
                    c.press_window = 16'd1;
                    c.required_presses = 4'd1;
                    c.changed_ticks = 16'd1;
                    c.feedback_ticks = 16'd1;
                end
                1:
                begin
                    c.start_mode = 1'b1;
                    c.press_window = 16'hFFFF;
                    c.required_presses = 4'd14;
                    c.changed_ticks = 16'hFFFF;
                    c.feedback_ticks = 16'hFFFF;
                end
                2:
                begin
                    c.press_window = 16'd0;
                    c.required_presses = 4'd0;
                    c.changed_ticks = 16'd0;
                    c.feedback_ticks = 16'd0;
                end
                3:
                begin
                    c.changed_ticks = 16'd0;
                    c.feedback_ticks = 16'd0;
                end
                4:
                begin
                    c.required_presses = PRESS_MAX;
                    c.press_window = 16'd40;
                end
                default: ;
            endcase
            set_regs(c);
            if (ph == 5)
                hold_rx = 1'b1;
            quota = (ph == 1 || ph == 2) ? 60 : 160;
            target = polls_sent + quota;
            while (polls_sent < target)
            begin
                case ($urandom_range(0, 9))
                    7, 8:
                    begin
                        repeat ($urandom_range(1, 8))
                        begin
                            tick_now = tick_now + 16'($urandom_range(0, 2));
                            offer($urandom_range(0, 7) == 0, tick_now, $urandom_range(0, 1),
                                  1'b0, '0);
                        end
                    end
                    9:
                    begin
                        tick_now = 16'($urandom);
                        offer($urandom_range(0, 7) == 0, tick_now, $urandom_range(0, 1),
                              1'b0, '0);
                    end
                    default: press_gesture();
                endcase
            end
        end

        drain();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
